// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SDH_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdh assertion failed");

// next-cycle implication
`define SDH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdh assertion failed");

`endif

// File: hw/rtl/sdh_pkg.sv
// ----------------------------------------------------------------------------
// sdh_pkg
// types and constants of the segment distance unit
// ----------------------------------------------------------------------------
`default_nettype none

package sdh_pkg;

  localparam int SQ_BITS   = 33;
  localparam int QUO_BITS  = 32;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF  = 1'b0,
    REG_EPSILON = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_COINC,
    KIND_POINT,
    KIND_LINE
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  gx_neg;
    logic  gy_neg;
    logic  hxy_neg;
  } side_t;

  typedef struct packed {
    logic [64:0] cr_mag;
    logic [31:0] gx_mag;
    logic [31:0] gy_mag;
    logic [63:0] sq_x;
    logic [63:0] sq_y;
    logic [63:0] sq_xy;
  } num_t;

  typedef struct packed {
    kind_t               kind;
    logic                gx_neg;
    logic                gy_neg;
    logic                hxy_neg;
    logic [SQ_BITS-1:0]  droot;
  } fin_t;

endpackage

`default_nettype wire

// File: hw/rtl/sdh_in_if.sv
// ----------------------------------------------------------------------------
// sdh_in_if
// query channel: point, segment and presence flag
// ----------------------------------------------------------------------------
`default_nettype none

interface sdh_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] seg_start_x;
  logic signed [31:0] seg_start_y;
  logic signed [31:0] seg_end_x;
  logic signed [31:0] seg_end_y;
  logic               seg_present;

  modport source (output valid, point_x, point_y, seg_start_x, seg_start_y,
                  seg_end_x, seg_end_y, seg_present, input ready);
  modport sink   (input valid, point_x, point_y, seg_start_x, seg_start_y,
                  seg_end_x, seg_end_y, seg_present, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sdh_out_if.sv
// ----------------------------------------------------------------------------
// sdh_out_if
// result channel: distance, gradient and hessian
// ----------------------------------------------------------------------------
`default_nettype none

interface sdh_out_if;
  logic               valid;
  logic               ready;
  logic        [30:0] distance;
  logic signed [31:0] grad_x;
  logic signed [31:0] grad_y;
  logic signed [31:0] hess_xx;
  logic signed [31:0] hess_yy;
  logic signed [31:0] hess_xy;

  modport source (output valid, distance, grad_x, grad_y, hess_xx, hess_yy, hess_xy,
                  input ready);
  modport sink   (input valid, distance, grad_x, grad_y, hess_xx, hess_yy, hess_xy,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sdh_cfg_if.sv
// ----------------------------------------------------------------------------
// sdh_cfg_if
// register write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface sdh_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sdh_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sdh_sqrt.sv
// ----------------------------------------------------------------------------
// sdh_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module sdh_sqrt (
  input  logic                            clk,
  input  logic                            en,
  input  logic [2*sdh_pkg::SQ_BITS-1:0]   radicand,
  output logic [sdh_pkg::SQ_BITS-1:0]     root
);

  localparam int N = sdh_pkg::SQ_BITS;

  logic [N:0]     rem_q  [N];
  logic [N-1:0]   root_q [N];
  logic [2*N-1:0] v_q    [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [N:0]     rem_i;
    logic [N-1:0]   root_i;
    logic [2*N-1:0] v_i;
    logic [N+2:0]   rsh;
    logic [N+2:0]   trial;
    logic [N+2:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign v_i    = radicand;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign v_i    = v_q[k-1];
    end

    assign rsh   = {rem_i, v_i[2*N-1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign diff  = rsh - trial;
    assign ge    = rsh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[N:0] : rsh[N:0];
        root_q[k] <= {root_i[N-2:0], ge};
        v_q[k]    <= {v_i[2*N-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[N-1];

endmodule

`default_nettype wire

// File: hw/rtl/sdh_div.sv
// ----------------------------------------------------------------------------
// sdh_div
// pipelined rounding divider, one quotient bit per stage, overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

module sdh_div #(
  parameter int NW = 64,
  parameter int DW = 33,
  parameter int QB = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo,
  output logic          ovf
);

  localparam int MW  = (NW > DW) ? NW : DW;
  localparam int NRW = MW + 2;
  localparam int RW  = DW + 2;
  localparam int TW  = ((NRW - QB) > RW) ? (NRW - QB) : RW;

  logic [NRW-1:0] nr;
  logic [DW:0]    dr;
  logic [TW-1:0]  top_x;

  logic [RW-1:0]  rem_q  [QB+1];
  logic [QB-1:0]  nlo_q  [QB+1];
  logic [QB-1:0]  q_q    [QB+1];
  logic [DW:0]    dr_q   [QB+1];
  logic           ovf_q  [QB+1];

  // round half up: floor((2n + d) / 2d)
  assign nr    = NRW'({num, 1'b0}) + NRW'(den);
  assign dr    = {den, 1'b0};
  assign top_x = TW'(nr[NRW-1:QB]);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= top_x[RW-1:0];
      nlo_q[0] <= nr[QB-1:0];
      q_q[0]   <= '0;
      dr_q[0]  <= dr;
      ovf_q[0] <= top_x >= TW'(dr);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [RW-1:0] rs;
    logic [RW-1:0] diff;
    logic          ge;

    assign rs   = {rem_q[k-1][RW-2:0], nlo_q[k-1][QB-1]};
    assign diff = rs - RW'(dr_q[k-1]);
    assign ge   = rs >= RW'(dr_q[k-1]);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff : rs;
        nlo_q[k] <= {nlo_q[k-1][QB-2:0], 1'b0};
        q_q[k]   <= {q_q[k-1][QB-2:0], ge};
        dr_q[k]  <= dr_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo = q_q[QB];
  assign ovf = ovf_q[QB];

endmodule

`default_nettype wire

// File: hw/rtl/segment_distance_with_hessian_unit.sv
// throughput: one word per cycle unless stalled, the whole pipeline advances together
// depth set by the 33-stage square root and the 33-stage dividers
// a stalled output holds every stage, nothing is dropped or repeated
// reset clears the valid bits and loads the register defaults
// ----------------------------------------------------------------------------
// segment_distance_with_hessian_unit
// point to segment distance with gradient and hessian, Q16.16
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module segment_distance_with_hessian_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  sdh_cfg_if.sink    cfg,
  sdh_in_if.sink     query,
  sdh_out_if.source  result
);

  localparam int N       = sdh_pkg::SQ_BITS;
  localparam int QB      = sdh_pkg::QUO_BITS;
  localparam int DIV_LAT = QB + 1;
  localparam int NST     = 8 + N + DIV_LAT;
  localparam int ALEN    = N + 3;
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  function automatic logic [64:0] mag66(input logic signed [65:0] x);
    logic [65:0] n;
    n = -x;
    return x[65] ? n[64:0] : x[64:0];
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] x);
    logic [32:0] n;
    n = -x;
    return x[32] ? n[31:0] : x[31:0];
  endfunction

  function automatic logic [31:0] sat_s32(input logic [31:0] q, input logic ov,
                                          input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (ov || q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
    end else begin
      r = (ov || q[31]) ? 32'h7FFF_FFFF : q;
    end
    return r;
  endfunction

  function automatic logic [30:0] sat_u31(input logic [31:0] q, input logic ov);
    return (ov || q[31]) ? 31'h7FFF_FFFF : q[30:0];
  endfunction

  // config registers
  logic [30:0] cutoff;
  logic [15:0] eps;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= 31'd655360;
      eps    <= 16'd1;
    end else if (cfg.valid) begin
      unique case (sdh_pkg::reg_idx_t'(cfg.index))
        sdh_pkg::REG_CUTOFF:  cutoff <= cfg.data[30:0];
        sdh_pkg::REG_EPSILON: eps    <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NST-1:0] vld;
  logic           adv;

  assign adv         = !vld[NST-1] || result.ready;
  assign query.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], query.valid};
    end
  end

  // stage 1: differences
  logic signed [32:0] ux1, uy1, ax1, ay1, bx1, by1;
  logic               pres1;

  always_ff @(posedge clk) begin
    if (adv) begin
      ux1   <= {query.seg_end_x[31], query.seg_end_x} -
               {query.seg_start_x[31], query.seg_start_x};
      uy1   <= {query.seg_end_y[31], query.seg_end_y} -
               {query.seg_start_y[31], query.seg_start_y};
      ax1   <= {query.point_x[31], query.point_x} -
               {query.seg_start_x[31], query.seg_start_x};
      ay1   <= {query.point_y[31], query.point_y} -
               {query.seg_start_y[31], query.seg_start_y};
      bx1   <= {query.point_x[31], query.point_x} -
               {query.seg_end_x[31], query.seg_end_x};
      by1   <= {query.point_y[31], query.point_y} -
               {query.seg_end_y[31], query.seg_end_y};
      pres1 <= query.seg_present;
    end
  end

  // stage 2: products
  logic signed [65:0] p_uxux, p_uyuy, p_axux, p_ayuy, p_uxay, p_uyax;
  logic signed [65:0] p_axax, p_ayay, p_axay, p_bxbx, p_byby, p_bxby;
  logic signed [32:0] ux2, uy2, ax2, ay2, bx2, by2;
  logic               pres2;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_uxux <= ux1 * ux1;
      p_uyuy <= uy1 * uy1;
      p_axux <= ax1 * ux1;
      p_ayuy <= ay1 * uy1;
      p_uxay <= ux1 * ay1;
      p_uyax <= uy1 * ax1;
      p_axax <= ax1 * ax1;
      p_ayay <= ay1 * ay1;
      p_axay <= ax1 * ay1;
      p_bxbx <= bx1 * bx1;
      p_byby <= by1 * by1;
      p_bxby <= bx1 * by1;
      ux2    <= ux1;
      uy2    <= uy1;
      ax2    <= ax1;
      ay2    <= ay1;
      bx2    <= bx1;
      by2    <= by1;
      pres2  <= pres1;
    end
  end

  // stage 3: sums
  logic        [64:0] len2, da2, db2;
  logic signed [65:0] dot, cr, axay3, bxby3;
  logic        [31:0] eps2;
  logic        [63:0] sq_ax, sq_ay, sq_bx, sq_by;
  logic signed [32:0] ux3, uy3, ax3, ay3, bx3, by3;
  logic               pres3;

  always_ff @(posedge clk) begin
    if (adv) begin
      len2  <= {1'b0, p_uxux[63:0]} + {1'b0, p_uyuy[63:0]};
      da2   <= {1'b0, p_axax[63:0]} + {1'b0, p_ayay[63:0]};
      db2   <= {1'b0, p_bxbx[63:0]} + {1'b0, p_byby[63:0]};
      dot   <= p_axux + p_ayuy;
      cr    <= p_uxay - p_uyax;
      eps2  <= {16'b0, eps} * {16'b0, eps};
      sq_ax <= p_axax[63:0];
      sq_ay <= p_ayay[63:0];
      sq_bx <= p_bxbx[63:0];
      sq_by <= p_byby[63:0];
      axay3 <= p_axay;
      bxby3 <= p_bxby;
      ux3   <= ux2;
      uy3   <= uy2;
      ax3   <= ax2;
      ay3   <= ay2;
      bx3   <= bx2;
      by3   <= by2;
      pres3 <= pres2;
    end
  end

  // stage 4: feature choice
  logic               is_start, is_end, coinc_a, coinc_b, cpos;
  logic signed [32:0] dx, dy;
  sdh_pkg::side_t     side_next, side4;
  sdh_pkg::num_t      num_next, num4;
  logic        [64:0] s_next, s4;

  assign is_start = dot[65] || (dot == '0) || (len2 <= 65'(eps2));
  assign is_end   = dot >= $signed({1'b0, len2});
  assign coinc_a  = (da2 < 65'(eps2)) || (da2 == '0);
  assign coinc_b  = (db2 < 65'(eps2)) || (db2 == '0);
  assign cpos     = !cr[65] && (cr != '0);
  assign dx       = is_start ? ax3 : bx3;
  assign dy       = is_start ? ay3 : by3;

  always_comb begin
    side_next.gx_neg  = dx[32];
    side_next.gy_neg  = dy[32];
    side_next.hxy_neg = dx[32] ^ dy[32];
    num_next.cr_mag   = mag66(cr);
    num_next.gx_mag   = mag33(dx);
    num_next.gy_mag   = mag33(dy);
    num_next.sq_x     = is_start ? sq_ax : sq_bx;
    num_next.sq_y     = is_start ? sq_ay : sq_by;
    num_next.sq_xy    = 64'(is_start ? mag66(axay3) : mag66(bxby3));
    s_next            = is_start ? da2 : db2;
    priority if (!pres3) begin
      side_next.kind = sdh_pkg::KIND_NONE;
    end else if (is_start) begin
      side_next.kind = coinc_a ? sdh_pkg::KIND_COINC : sdh_pkg::KIND_POINT;
    end else if (is_end) begin
      side_next.kind = coinc_b ? sdh_pkg::KIND_COINC : sdh_pkg::KIND_POINT;
    end else begin
      side_next.kind   = sdh_pkg::KIND_LINE;
      side_next.gx_neg = cpos ^ uy3[32];
      side_next.gy_neg = !cpos ^ ux3[32];
      num_next.gx_mag  = mag33(uy3);
      num_next.gy_mag  = mag33(ux3);
      s_next           = len2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side4 <= side_next;
      num4  <= num_next;
      s4    <= s_next;
    end
  end

  // square root of the selected squared length
  logic [2*N-1:0] rad;
  logic [N-1:0]   root;

  assign rad = {1'b0, s4};

  sdh_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (rad),
    .root     (root)
  );

  sdh_pkg::side_t side_q [ALEN];
  sdh_pkg::num_t  num_q  [ALEN];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= side4;
      num_q[0]  <= num4;
      for (int i = 1; i < ALEN; i++) begin
        side_q[i] <= side_q[i-1];
        num_q[i]  <= num_q[i-1];
      end
    end
  end

  // cube of the root
  logic [N-1:0]   d_e1, d_e2, d_e3;
  logic [2*N-1:0] dd_e1;
  logic [2*N-1:0] plo_e2, phi_e2;
  logic [3*N-1:0] d3_e3;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_e1   <= root;
      dd_e1  <= root * root;
      d_e2   <= d_e1;
      plo_e2 <= dd_e1[N-1:0] * d_e1;
      phi_e2 <= dd_e1[2*N-1:N] * d_e1;
      d_e3   <= d_e2;
      d3_e3  <= {phi_e2, {N{1'b0}}} + (3*N)'(plo_e2);
    end
  end

  // dividers
  sdh_pkg::num_t nm;
  logic [QB-1:0] q_dist, q_gx, q_gy, q_hxx, q_hyy, q_hxy;
  logic          o_dist, o_gx, o_gy, o_hxx, o_hyy, o_hxy;

  assign nm = num_q[ALEN-1];

  sdh_div #(.NW(65), .DW(N), .QB(QB)) u_div_dist (
    .clk (clk), .en (adv), .num (nm.cr_mag), .den (d_e3), .quo (q_dist), .ovf (o_dist)
  );

  sdh_div #(.NW(32 + FRAC_BITS), .DW(N), .QB(QB)) u_div_gx (
    .clk (clk), .en (adv), .num ({nm.gx_mag, {FRAC_BITS{1'b0}}}), .den (d_e3),
    .quo (q_gx), .ovf (o_gx)
  );

  sdh_div #(.NW(32 + FRAC_BITS), .DW(N), .QB(QB)) u_div_gy (
    .clk (clk), .en (adv), .num ({nm.gy_mag, {FRAC_BITS{1'b0}}}), .den (d_e3),
    .quo (q_gy), .ovf (o_gy)
  );

  sdh_div #(.NW(64 + 2*FRAC_BITS), .DW(3*N), .QB(QB)) u_div_hxx (
    .clk (clk), .en (adv), .num ({nm.sq_y, {(2*FRAC_BITS){1'b0}}}), .den (d3_e3),
    .quo (q_hxx), .ovf (o_hxx)
  );

  sdh_div #(.NW(64 + 2*FRAC_BITS), .DW(3*N), .QB(QB)) u_div_hyy (
    .clk (clk), .en (adv), .num ({nm.sq_x, {(2*FRAC_BITS){1'b0}}}), .den (d3_e3),
    .quo (q_hyy), .ovf (o_hyy)
  );

  sdh_div #(.NW(64 + 2*FRAC_BITS), .DW(3*N), .QB(QB)) u_div_hxy (
    .clk (clk), .en (adv), .num ({nm.sq_xy, {(2*FRAC_BITS){1'b0}}}), .den (d3_e3),
    .quo (q_hxy), .ovf (o_hxy)
  );

  sdh_pkg::fin_t fin_q [DIV_LAT];
  sdh_pkg::fin_t fin;

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_q[0].kind    <= side_q[ALEN-1].kind;
      fin_q[0].gx_neg  <= side_q[ALEN-1].gx_neg;
      fin_q[0].gy_neg  <= side_q[ALEN-1].gy_neg;
      fin_q[0].hxy_neg <= side_q[ALEN-1].hxy_neg;
      fin_q[0].droot   <= d_e3;
      for (int i = 1; i < DIV_LAT; i++) begin
        fin_q[i] <= fin_q[i-1];
      end
    end
  end

  assign fin = fin_q[DIV_LAT-1];

  // output register
  sdh_pkg::kind_t out_kind;
  logic [30:0]    out_distance;
  logic [31:0]    out_gx, out_gy, out_hxx, out_hyy, out_hxy;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind <= fin.kind;
      unique case (fin.kind)
        sdh_pkg::KIND_NONE: begin
          out_distance <= cutoff;
          out_gx       <= '0;
          out_gy       <= '0;
          out_hxx      <= '0;
          out_hyy      <= '0;
          out_hxy      <= '0;
        end
        sdh_pkg::KIND_COINC: begin
          out_distance <= '0;
          out_gx       <= ONE;
          out_gy       <= '0;
          out_hxx      <= '0;
          out_hyy      <= '0;
          out_hxy      <= '0;
        end
        sdh_pkg::KIND_POINT: begin
          out_distance <= sat_u31(fin.droot[31:0], fin.droot[N-1]);
          out_gx       <= sat_s32(q_gx, o_gx, fin.gx_neg);
          out_gy       <= sat_s32(q_gy, o_gy, fin.gy_neg);
          out_hxx      <= sat_s32(q_hxx, o_hxx, 1'b0);
          out_hyy      <= sat_s32(q_hyy, o_hyy, 1'b0);
          out_hxy      <= sat_s32(q_hxy, o_hxy, fin.hxy_neg);
        end
        sdh_pkg::KIND_LINE: begin
          out_distance <= sat_u31(q_dist, o_dist);
          out_gx       <= sat_s32(q_gx, o_gx, fin.gx_neg);
          out_gy       <= sat_s32(q_gy, o_gy, fin.gy_neg);
          out_hxx      <= '0;
          out_hyy      <= '0;
          out_hxy      <= '0;
        end
        default: ;
      endcase
    end
  end

  assign result.valid    = vld[NST-1];
  assign result.distance = out_distance;
  assign result.grad_x   = out_gx;
  assign result.grad_y   = out_gy;
  assign result.hess_xx  = out_hxx;
  assign result.hess_yy  = out_hyy;
  assign result.hess_xy  = out_hxy;

  // result word kind and hessian checks
  logic out_line, out_point, out_coinc, hess_zero, hess_diag_pos, coinc_ok;

  assign out_line      = result.valid && out_kind == sdh_pkg::KIND_LINE;
  assign out_point     = result.valid && out_kind == sdh_pkg::KIND_POINT;
  assign out_coinc     = result.valid && out_kind == sdh_pkg::KIND_COINC;
  assign hess_zero     = result.hess_xx == '0 && result.hess_yy == '0 &&
                         result.hess_xy == '0;
  assign hess_diag_pos = !result.hess_xx[31] && !result.hess_yy[31];
  assign coinc_ok      = result.distance == '0 && result.grad_x == ONE;

  `SDH_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld))
  `SDH_ASSERT_IMP(a_line_flat, out_line, hess_zero)
  `SDH_ASSERT_IMP(a_point_diag, out_point, hess_diag_pos)
  `SDH_ASSERT_IMP(a_coinc_unit, out_coinc, coinc_ok)

endmodule

`default_nettype wire

// File: bench/segment_distance_with_hessian_unit_test.sv
// ----------------------------------------------------------------------------
// segment_distance_with_hessian_unit_test
// drives points and segments through the distance unit under several register
// settings, predicts distance, gradient and hessian from exact wide integer
// arithmetic, and compares every result word in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module segment_distance_with_hessian_unit_test;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_PHASE = 340;

  typedef logic signed [129:0] wide_s;
  typedef logic [129:0] wide_u;

  typedef struct {
    logic signed [31:0] px, py, sx, sy, ex, ey;
    logic present;
  } query_t;

  typedef struct {
    logic [30:0] distance;
    logic signed [31:0] gx, gy, hxx, hyy, hxy;
  } dist_result_t;

  class distance_scoreboard;
    logic [30:0] cutoff = 31'd655360;
    logic [15:0] eps = 16'd1;
    dist_result_t pending[$];
    int errors = 0;

    function wide_u round_div(wide_u n, wide_u d);
      return ((n << 1) + d) / (d << 1);
    endfunction

    function wide_u isqrt(wide_u v);
      wide_u r, t;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
        t = r | (wide_u'(1) << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function wide_u mag(wide_s v);
      return v < 0 ? wide_u'(-v) : wide_u'(v);
    endfunction

    function logic [31:0] sat32(wide_u m, bit neg);
      if (neg) return (m > 130'h80000000) ? 32'h80000000 : 32'(-m);
      return (m > 130'h7fffffff) ? 32'h7fffffff : 32'(m);
    endfunction

    function logic [30:0] sat31(wide_u m);
      return (m > 130'h7fffffff) ? 31'h7fffffff : 31'(m);
    endfunction

    function dist_result_t near_end(wide_s dx, wide_s dy, wide_s eps2);
      dist_result_t r;
      wide_s d2;
      wide_u dd, d3;
      d2 = dx * dx + dy * dy;
      r = '{distance: 0, gx: 0, gy: 0, hxx: 0, hyy: 0, hxy: 0};
      if (d2 < eps2 || d2 == 0) begin
        r.gx = 32'sd1 <<< FRAC;
        return r;
      end
      dd = isqrt(wide_u'(d2));
      d3 = dd * dd * dd;
      r.distance = sat31(dd);
      r.gx = sat32(round_div(mag(dx) << FRAC, dd), dx < 0);
      r.gy = sat32(round_div(mag(dy) << FRAC, dd), dy < 0);
      r.hxx = sat32(round_div((mag(dy) * mag(dy)) << (2 * FRAC), d3), 1'b0);
      r.hyy = sat32(round_div((mag(dx) * mag(dx)) << (2 * FRAC), d3), 1'b0);
      r.hxy = sat32(round_div((mag(dx) * mag(dy)) << (2 * FRAC), d3),
                    (dx < 0) != (dy < 0));
      return r;
    endfunction

    function dist_result_t predict(query_t q);
      dist_result_t r;
      wide_s px, py, sx, sy, ex, ey, ux, uy, ax, ay, len2, dot, eps2, cr, nx, ny;
      wide_u len;
      px = q.px; py = q.py; sx = q.sx; sy = q.sy; ex = q.ex; ey = q.ey;
      r = '{distance: cutoff, gx: 0, gy: 0, hxx: 0, hyy: 0, hxy: 0};
      if (!q.present) return r;
      ux = ex - sx; uy = ey - sy; ax = px - sx; ay = py - sy;
      len2 = ux * ux + uy * uy;
      dot = ax * ux + ay * uy;
      eps2 = wide_s'(eps) * wide_s'(eps);
      if (dot <= 0 || len2 <= eps2) return near_end(ax, ay, eps2);
      if (dot >= len2) return near_end(px - ex, py - ey, eps2);
      len = isqrt(wide_u'(len2));
      cr = ux * ay - uy * ax;
      if (cr > 0) begin
        nx = -uy; ny = ux;
      end else begin
        nx = uy; ny = -ux; cr = -cr;
      end
      r.distance = sat31(round_div(wide_u'(cr), len));
      r.gx = sat32(round_div(mag(nx) << FRAC, len), nx < 0);
      r.gy = sat32(round_div(mag(ny) << FRAC, len), ny < 0);
      return r;
    endfunction

    function void write_reg(sdh_pkg::reg_idx_t idx, logic [31:0] data);
      if (idx == sdh_pkg::REG_CUTOFF) cutoff = data[30:0];
      else if (idx == sdh_pkg::REG_EPSILON) eps = data[15:0];
    endfunction

    function void note_query(query_t q);
      pending.push_back(predict(q));
    endfunction

    function void field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(dist_result_t got);
      dist_result_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      field("distance", want.distance, got.distance);
      field("grad_x", want.gx, got.gx);
      field("grad_y", want.gy, got.gy);
      field("hess_xx", want.hxx, got.hxx);
      field("hess_yy", want.hyy, got.hyy);
      field("hess_xy", want.hxy, got.hxy);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  int cycles = 0;
  int hold_off = 0;
  bit steady = 0;
  distance_scoreboard sb = new();

  sdh_cfg_if cfg_bus();
  sdh_in_if query_bus();
  sdh_out_if result_bus();

  segment_distance_with_hessian_unit u_top (
    .clk(clk), .rst(rst), .cfg(cfg_bus), .query(query_bus), .result(result_bus)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls plus an occasional long hold-off
  initial begin
    int stall;
    stall = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        result_bus.ready <= 1'b0;
        hold_off--;
      end else if (stall > 0) begin
        result_bus.ready <= 1'b0;
        stall--;
      end else begin
        result_bus.ready <= 1'b1;
        stall = idle_len();
      end
    end
  end

  // outputs are stable between edges, sample in the middle of the cycle
  always @(negedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      sb.check_result('{distance: result_bus.distance, gx: result_bus.grad_x,
                        gy: result_bus.grad_y, hxx: result_bus.hess_xx,
                        hyy: result_bus.hess_yy, hxy: result_bus.hess_xy});
  end

  task automatic send_query(query_t q);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      query_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query_bus.valid <= 1'b1;
    query_bus.point_x <= q.px;
    query_bus.point_y <= q.py;
    query_bus.seg_start_x <= q.sx;
    query_bus.seg_start_y <= q.sy;
    query_bus.seg_end_x <= q.ex;
    query_bus.seg_end_y <= q.ey;
    query_bus.seg_present <= q.present;
    do @(negedge clk); while (!query_bus.ready);
    @(posedge clk);
    sb.note_query(q);
  endtask

  task automatic write_reg(sdh_pkg::reg_idx_t idx, logic [31:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(negedge clk); while (!cfg_bus.ready);
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    query_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function logic signed [31:0] coord();
    return $signed($urandom) >>> $urandom_range(0, 30);
  endfunction

  function logic signed [31:0] jitter(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function query_t random_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 9);
    q = '{px: coord(), py: coord(), sx: coord(), sy: coord(), ex: coord(),
          ey: coord(), present: 1'b1};
    case (mode)
      0: begin
        q = '{px: $urandom, py: $urandom, sx: $urandom, sy: $urandom, ex: $urandom,
              ey: $urandom, present: $urandom_range(0, 1)};
      end
      1: q.present = 1'b0;
      5: begin
        q.ex = q.sx + jitter(2);
        q.ey = q.sy + jitter(2);
      end
      6: begin
        q.px = q.sx + jitter(3);
        q.py = q.sy + jitter(3);
      end
      7: begin
        q.px = q.ex + jitter(3);
        q.py = q.ey + jitter(3);
      end
      8: begin
        q.px = (q.sx >>> 1) + (q.ex >>> 1) + jitter(4);
        q.py = (q.sy >>> 1) + (q.ey >>> 1) + jitter(4);
      end
      default: ;
    endcase
    return q;
  endfunction

  function query_t mk(int px, int py, int sx, int sy, int ex, int ey, bit pres);
    return '{px: px, py: py, sx: sx, sy: sy, ex: ex, ey: ey, present: pres};
  endfunction

  localparam int ONE = 65536;
  localparam int MAXI = 32'h7fffffff;
  localparam int MINI = 32'h80000000;

  initial begin
    query_t directed[$];
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= sdh_pkg::REG_CUTOFF;
    cfg_bus.data <= '0;
    query_bus.valid <= 1'b0;
    query_bus.point_x <= '0;
    query_bus.point_y <= '0;
    query_bus.seg_start_x <= '0;
    query_bus.seg_start_y <= '0;
    query_bus.seg_end_x <= '0;
    query_bus.seg_end_y <= '0;
    query_bus.seg_present <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed = '{
      mk(3 * ONE, 4 * ONE, 0, 0, ONE, 0, 1'b0),                  // no segment
      mk(MAXI, MINI, MINI, MAXI, MAXI, MINI, 1'b0),
      mk(ONE, ONE, ONE, ONE, 5 * ONE, ONE, 1'b1),                // on start point
      mk(5 * ONE, ONE, ONE, ONE, 5 * ONE, ONE, 1'b1),            // on end point
      mk(2 * ONE, 3 * ONE, 2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE, 1'b1), // zero length
      mk(-3 * ONE, 4 * ONE, 0, 0, 10 * ONE, 0, 1'b1),            // before start
      mk(0, 4 * ONE, 0, 0, 10 * ONE, 0, 1'b1),                   // projection at start
      mk(10 * ONE, -4 * ONE, 0, 0, 10 * ONE, 0, 1'b1),           // projection at end
      mk(13 * ONE, 4 * ONE, 0, 0, 10 * ONE, 0, 1'b1),            // past end
      mk(5 * ONE, 4 * ONE, 0, 0, 10 * ONE, 0, 1'b1),             // line, left side
      mk(5 * ONE, -4 * ONE, 0, 0, 10 * ONE, 0, 1'b1),            // line, right side
      mk(5 * ONE, 0, 0, 0, 10 * ONE, 0, 1'b1),                   // on the line
      mk(ONE, 2 * ONE, 0, 0, 3 * ONE, 3 * ONE, 1'b1),
      mk(MAXI, MAXI, MINI, MINI, MINI, MINI, 1'b1),              // saturating point
      mk(MINI, MAXI, MAXI, MINI, MAXI, MINI, 1'b1),
      mk(MAXI, MINI, MINI, MINI, MAXI, MAXI, 1'b1),              // huge segment
      mk(0, MAXI, MINI, 0, MAXI, 0, 1'b1),
      mk(MINI, MINI, MINI, MINI, MAXI, MAXI, 1'b1),
      mk(1, 0, 0, 0, 1, 1, 1'b1),
      mk(0, 1, 0, 0, 2, 0, 1'b1),
      mk(-1, -1, 0, 0, MAXI, MAXI, 1'b1)
    };
    foreach (directed[i]) send_query(directed[i]);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          write_reg(sdh_pkg::REG_CUTOFF, 32'h0);
          write_reg(sdh_pkg::REG_EPSILON, 32'h0);
          steady = 1;
        end
        2: begin
          write_reg(sdh_pkg::REG_CUTOFF, 32'hffffffff);
          write_reg(sdh_pkg::REG_EPSILON, 32'h0000ffff);
          steady = 0;
          hold_off = 400;
        end
        3: begin
          write_reg(sdh_pkg::REG_CUTOFF, $urandom);
          write_reg(sdh_pkg::REG_EPSILON, $urandom);
        end
        default: ;
      endcase
      if (phase == 1) begin
        // exercise the zero threshold on exact coincidence
        send_query(mk(7, 9, 7, 9, 7, 9, 1'b1));
        send_query(mk(ONE, 0, 0, 0, ONE, 0, 1'b1));
      end
      repeat (ITEMS_PER_PHASE) send_query(random_query());
      drain();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
